// File: sv/hvn_pkg.sv
// Shared types, constants and codes for the heightmap vertex normal stream.
package hvn_pkg;

    localparam int MAX_GRID_DEF = 256;
    localparam int MIN_GRID = 3;
    localparam logic [8:0] GRID_SIZE_RST = 9'd256;
    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd10240;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
    // Square of the vertical term, 2.0 in Q3.12, as a power of two.
    localparam int SLOPE_SQ_LOG2 = 26;
    localparam int SRCH_W = 72;
    localparam int STEPS = 16;

    localparam logic [1:0] KIND_IGNORE = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;
    localparam logic [1:0] KIND_VERTEX = 2'd3;

    localparam logic [1:0] RD_CENTER = 2'd0;
    localparam logic [1:0] RD_OLD = 2'd1;
    localparam logic [1:0] RD_RIGHT = 2'd2;
    localparam logic [1:0] RD_LEFT = 2'd3;

    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic REG_HEIGHT_SCALE = 1'b1;

    typedef struct packed {
        logic command;
        logic signed [15:0] height;
    } in_word_t;

    typedef struct packed {
        logic [7:0] grid_row;
        logic [7:0] grid_col;
        logic signed [31:0] elevation;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic mesh_last;
    } out_word_t;

    typedef struct packed {
        logic item_load;
        logic rd_en;
        logic [1:0] rd_sel;
        logic wr_en;
        logic advance;
        logic sq_x;
        logic sq_z;
        logic iter_step;
        logic [3:0] iter_bit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic interior;
        logic out_busy;
    } dp_status_t;

endpackage

// File: sv/hvn_ram.sv
// Generic simple dual-port RAM with registered read data.
module hvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/hvn_ctrl.sv
// Controller state machine sequencing reads, the normal search and output.
module hvn_ctrl import hvn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_RD_O = 4'd2;
    localparam logic [3:0] ST_RD_R = 4'd3;
    localparam logic [3:0] ST_RD_L = 4'd4;
    localparam logic [3:0] ST_CAPW = 4'd5;
    localparam logic [3:0] ST_SQ_X = 4'd6;
    localparam logic [3:0] ST_SQ_Z = 4'd7;
    localparam logic [3:0] ST_ITER = 4'd8;
    localparam logic [3:0] ST_OUT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            kind_reg <= KIND_IGNORE;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            kind_reg <= kind_next;
        end
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        state_next = state_reg;
        cnt_next = cnt_reg;
        kind_next = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                kind_next = status.kind;
                case (status.kind)
                    KIND_WRITE: begin
                        state_next = ST_CAPW;
                    end
                    KIND_DRAIN: begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_sel = RD_CENTER;
                        state_next = ST_CAPW;
                    end
                    KIND_VERTEX: begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_sel = RD_CENTER;
                        state_next = status.interior ? ST_RD_O : ST_CAPW;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_O: begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_OLD;
                state_next = ST_RD_R;
            end
            ST_RD_R: begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_RIGHT;
                state_next = ST_RD_L;
            end
            ST_RD_L: begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_LEFT;
                state_next = ST_CAPW;
            end
            ST_CAPW: begin
                if (kind_reg != KIND_DRAIN) begin
                    cmd.wr_en = 1'b1;
                    cmd.advance = 1'b1;
                end
                state_next = (kind_reg == KIND_WRITE) ? ST_IDLE : ST_SQ_X;
            end
            ST_SQ_X: begin
                cmd.sq_x = 1'b1;
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                cmd.sq_z = 1'b1;
                cnt_next = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.iter_step = 1'b1;
                cmd.iter_bit = ~cnt_reg;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/hvn_dpath.sv
// Datapath: line store, stream position, normal search, texture division, output.
module hvn_dpath import hvn_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_word_t    s_data,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [8:0]  grid_size,
    input  logic [15:0] height_scale,
    input  logic        size_wr,
    input  logic        m_ready,
    output logic        m_valid,
    output out_word_t   m_data
);

    localparam int COL_W = $clog2(MAX_GRID);
    localparam int CNT_W = $clog2(MAX_GRID + 1);
    localparam int ADDR_W = $clog2(2 * MAX_GRID);
    localparam int REM_W = CNT_W + 1;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_reg, drain_col_reg;
    logic [CNT_W-1:0] in_col_p1, drain_p1;
    logic complete, interior_in;

    in_word_t item_reg;
    logic [CNT_W-1:0] vrow_reg;
    logic [COL_W-1:0] vcol_reg;
    logic interior_reg, last_reg;

    logic signed [15:0] hc_reg, ho_reg, hr_reg, hl_reg;
    logic rd_pend_reg;
    logic [1:0] rd_sel_q_reg;
    logic rd_slot, wr_slot;
    logic [COL_W-1:0] rd_col;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [15:0] rd_data;

    logic signed [16:0] dx, dz;
    logic [16:0] sq_op;
    logic [33:0] sq_full;
    logic [31:0] sqx_reg, sqz_reg;
    logic dx_pos_reg, dz_pos_reg;
    logic [SRCH_W-1:0] s_reg;
    logic [SRCH_W-1:0] a_reg [3];
    logic [SRCH_W-1:0] b_reg [3];
    logic [15:0] q_reg [3];
    logic [SRCH_W-1:0] t4 [3];
    logic [SRCH_W-1:0] a_cand [3];
    logic [SRCH_W-1:0] b_cand [3];
    logic take [3];

    logic [REM_W-1:0] rem_u_reg, rem_v_reg, rem_u2, rem_v2;
    logic [15:0] quo_u_reg, quo_v_reg;
    logic ge_u, ge_v;

    logic signed [32:0] prod;
    logic signed [31:0] elev;
    out_word_t out_reg;
    logic m_valid_reg;

    always_comb begin
        if (grid_size < 9'(MIN_GRID)) begin
            n_eff = CNT_W'(MIN_GRID);
        end else if (32'(grid_size) > 32'(MAX_GRID)) begin
            n_eff = CNT_W'(MAX_GRID);
        end else begin
            n_eff = CNT_W'(grid_size);
        end
    end

    assign complete = in_row_reg >= n_eff;
    assign in_col_p1 = CNT_W'(in_col_reg) + CNT_W'(1);
    assign drain_p1 = CNT_W'(drain_col_reg) + CNT_W'(1);
    assign interior_in = (in_row_reg >= CNT_W'(2)) && (in_col_reg != '0) &&
                         (REM_W'(in_col_reg) + REM_W'(2) <= REM_W'(n_eff));

    always_comb begin
        status.out_busy = m_valid_reg && !m_ready;
        status.interior = interior_reg;
        if (item_reg.command) begin
            status.kind = complete ? KIND_DRAIN : KIND_IGNORE;
        end else if (complete) begin
            status.kind = KIND_IGNORE;
        end else if (in_row_reg == '0) begin
            status.kind = KIND_WRITE;
        end else begin
            status.kind = KIND_VERTEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
            vrow_reg <= s_data.command ? n_eff - CNT_W'(1) : in_row_reg - CNT_W'(1);
            vcol_reg <= s_data.command ? drain_col_reg : in_col_reg;
            interior_reg <= !s_data.command && interior_in;
            last_reg <= s_data.command && (drain_p1 >= n_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || size_wr) begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            drain_col_reg <= '0;
        end else begin
            if (cmd.advance) begin
                if (in_col_p1 >= n_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + CNT_W'(1);
                end else begin
                    in_col_reg <= COL_W'(in_col_p1);
                end
            end
            if (cmd.out_load && item_reg.command) begin
                if (last_reg) begin
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    drain_col_reg <= '0;
                end else begin
                    drain_col_reg <= COL_W'(drain_p1);
                end
            end
        end
    end

    always_comb begin
        rd_slot = vrow_reg[0];
        rd_col = vcol_reg;
        case (cmd.rd_sel)
            RD_OLD: begin
                rd_slot = in_row_reg[0];
                rd_col = in_col_reg;
            end
            RD_RIGHT: begin
                rd_col = vcol_reg + COL_W'(1);
            end
            RD_LEFT: begin
                rd_col = vcol_reg - COL_W'(1);
            end
            default: begin
                rd_col = vcol_reg;
            end
        endcase
        wr_slot = in_row_reg[0];
        rd_addr = rd_slot ? ADDR_W'(MAX_GRID) + ADDR_W'(rd_col) : ADDR_W'(rd_col);
        wr_addr = wr_slot ? ADDR_W'(MAX_GRID) + ADDR_W'(in_col_reg) : ADDR_W'(in_col_reg);
    end

    hvn_ram #(
        .WIDTH(16),
        .DEPTH(2 * MAX_GRID)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (cmd.wr_en),
        .wr_addr(wr_addr),
        .wr_data(item_reg.height),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
        end
        rd_sel_q_reg <= cmd.rd_sel;
        if (rd_pend_reg) begin
            case (rd_sel_q_reg)
                RD_OLD: ho_reg <= rd_data;
                RD_RIGHT: hr_reg <= rd_data;
                RD_LEFT: hl_reg <= rd_data;
                default: hc_reg <= rd_data;
            endcase
        end
    end

    assign dx = 17'(item_reg.height) - 17'(ho_reg);
    assign dz = 17'(hr_reg) - 17'(hl_reg);

    always_comb begin
        if (cmd.sq_x) begin
            sq_op = dx[16] ? 17'(-dx) : 17'(dx);
        end else begin
            sq_op = dz[16] ? 17'(-dz) : 17'(dz);
        end
    end

    assign sq_full = 34'(sq_op) * 34'(sq_op);

    assign t4[0] = SRCH_W'(sqx_reg) << 30;
    assign t4[1] = SRCH_W'(1) << (SLOPE_SQ_LOG2 + 30);
    assign t4[2] = SRCH_W'(sqz_reg) << 30;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            a_cand[l] = a_reg[l] + (b_reg[l] << ({1'b0, cmd.iter_bit} + 5'd1)) +
                        (s_reg << {cmd.iter_bit, 1'b0});
            b_cand[l] = b_reg[l] + (s_reg << cmd.iter_bit);
            take[l] = ((a_cand[l] << 2) + s_reg) <= (t4[l] + (b_cand[l] << 2));
        end
    end

    assign rem_u2 = rem_u_reg << 1;
    assign rem_v2 = rem_v_reg << 1;
    assign ge_u = rem_u2 >= REM_W'(n_eff);
    assign ge_v = rem_v2 >= REM_W'(n_eff);

    always_ff @(posedge aclk) begin
        if (cmd.sq_x) begin
            sqx_reg <= sq_full[31:0];
            dx_pos_reg <= !dx[16] && (dx != '0);
        end
        if (cmd.sq_z) begin
            sqz_reg <= sq_full[31:0];
            dz_pos_reg <= !dz[16] && (dz != '0);
            s_reg <= SRCH_W'(sqx_reg) + SRCH_W'(sq_full[31:0]) +
                     (SRCH_W'(1) << SLOPE_SQ_LOG2);
            for (int l = 0; l < 3; l++) begin
                a_reg[l] <= '0;
                b_reg[l] <= '0;
                q_reg[l] <= '0;
            end
            rem_u_reg <= REM_W'(vrow_reg);
            rem_v_reg <= REM_W'(vcol_reg);
            quo_u_reg <= '0;
            quo_v_reg <= '0;
        end
        if (cmd.iter_step) begin
            for (int l = 0; l < 3; l++) begin
                if (take[l]) begin
                    a_reg[l] <= a_cand[l];
                    b_reg[l] <= b_cand[l];
                    q_reg[l] <= q_reg[l] | (16'd1 << cmd.iter_bit);
                end
            end
            rem_u_reg <= ge_u ? rem_u2 - REM_W'(n_eff) : rem_u2;
            rem_v_reg <= ge_v ? rem_v2 - REM_W'(n_eff) : rem_v2;
            quo_u_reg <= {quo_u_reg[14:0], ge_u};
            quo_v_reg <= {quo_v_reg[14:0], ge_v};
        end
    end

    assign prod = 33'(hc_reg) * $signed({17'd0, height_scale});

    always_comb begin
        if (prod > 33'sd2147483647) begin
            elev = 32'sh7FFFFFFF;
        end else if (prod < -33'sd2147483648) begin
            elev = 32'sh80000000;
        end else begin
            elev = prod[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg.grid_row <= 8'(vrow_reg);
            out_reg.grid_col <= 8'(vcol_reg);
            out_reg.elevation <= elev;
            if (interior_reg) begin
                out_reg.normal_x <= dx_pos_reg ? 16'd0 - q_reg[0] : q_reg[0];
                out_reg.normal_y <= q_reg[1];
                out_reg.normal_z <= dz_pos_reg ? 16'd0 - q_reg[2] : q_reg[2];
            end else begin
                out_reg.normal_x <= '0;
                out_reg.normal_y <= UNIT_Q14;
                out_reg.normal_z <= '0;
            end
            out_reg.tex_u <= quo_u_reg;
            out_reg.tex_v <= quo_v_reg;
            out_reg.mesh_last <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

endmodule

// File: sv/heightmap_vertex_normal_stream_core.sv
// The core accepts a new input word only after it has finished with the previous one; an output
// word that is still stalled holds it back. The normal search and the texture divider share one
// 16-step loop.
// Synchronous active-low reset clears the stream position and sets the registers to defaults.
// The line store is not cleared; the stream writes every entry before it reads it.
module heightmap_vertex_normal_stream_core import hvn_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] grid_size_reg;
    logic [15:0] height_scale_reg;
    logic wr_strobe, size_wr;
    ctrl_cmd_t cmd;
    dp_status_t status;

    assign pready = 1'b1;
    assign wr_strobe = psel && penable && pwrite;
    assign size_wr = wr_strobe && (paddr[2] == REG_GRID_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RST;
            height_scale_reg <= HEIGHT_SCALE_RST;
        end else if (wr_strobe) begin
            if (paddr[2] == REG_HEIGHT_SCALE) begin
                height_scale_reg <= pwdata[15:0];
            end else begin
                grid_size_reg <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT_SCALE) ? {16'd0, height_scale_reg}
                                                   : {23'd0, grid_size_reg};

    hvn_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    hvn_dpath #(
        .MAX_GRID(MAX_GRID)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .grid_size   (grid_size_reg),
        .height_scale(height_scale_reg),
        .size_wr     (size_wr),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

// File: sv/hvn_checker.sv
// Port-level checker for the heightmap vertex normal stream, bound to the top level.
module hvn_checker import hvn_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input out_word_t   m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Output word valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled output word changed.");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mesh_last |-> m_data.grid_row == m_data.grid_col)
        else $error("Final vertex is not on the diagonal corner.");

    a_first_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.grid_row == 8'd0) |->
        m_data.normal_x == 16'sd0 && m_data.normal_z == 16'sd0 &&
        m_data.normal_y == UNIT_Q14 && m_data.tex_u == 16'd0)
        else $error("First-row vertex lacks the upward border normal.");

endmodule

bind heightmap_vertex_normal_stream_core hvn_checker u_hvn_checker (.*);

// File: test/heightmap_vertex_normal_stream_core_tb.sv
// Self-checking testbench for the heightmap vertex normal stream core.
`timescale 1ns / 1ps

module heightmap_vertex_normal_stream_core_tb;
    import hvn_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;
    localparam int STORE_ROWS = MAX_GRID_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    in_word_t pending_words[$];
    out_word_t expected_vertices[$];

    logic signed [15:0] line_mem [0:2*STORE_ROWS-1];
    int unsigned next_row = 0;
    int unsigned next_col = 0;
    int unsigned drain_pos = 0;
    int unsigned grid_reg = GRID_SIZE_RST;
    int unsigned scale_reg = HEIGHT_SCALE_RST;

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int errors = 0;
    int vertices_checked = 0;
    int meshes_done = 0;
    int words_sent = 0;

    heightmap_vertex_normal_stream_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned grid_n(int unsigned v);
        if (v < MIN_GRID) return MIN_GRID;
        if (v > STORE_ROWS) return STORE_ROWS;
        return v;
    endfunction

    function automatic logic signed [15:0] stored_height(int unsigned row, int unsigned col);
        return line_mem[(row & 1) * STORE_ROWS + (col % STORE_ROWS)];
    endfunction

    function automatic logic signed [15:0] unit_component(longint c, longint unsigned s);
        longint unsigned a, t, t4, k;
        int unsigned lo, hi, mid;
        a = (c < 0) ? -c : c;
        t = a << 14;
        t4 = 4 * t * t;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k = 2 * longint'(mid) - 1;
            if (k * k * s <= t4) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? -16'(lo) : 16'(lo);
    endfunction

    function automatic out_word_t make_vertex(int unsigned row, int unsigned col,
            logic signed [15:0] h, logic signed [15:0] nx, logic signed [15:0] ny,
            logic signed [15:0] nz, int unsigned n, logic last);
        out_word_t v;
        longint e;
        e = longint'(h) * longint'(scale_reg);
        if (e > 64'sd2147483647) e = 64'sd2147483647;
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        v.grid_row = row[7:0];
        v.grid_col = col[7:0];
        v.elevation = e[31:0];
        v.normal_x = nx;
        v.normal_y = ny;
        v.normal_z = nz;
        v.tex_u = 16'((longint'(row) << 16) / n);
        v.tex_v = 16'((longint'(col) << 16) / n);
        v.mesh_last = last;
        return v;
    endfunction

    function automatic void predict_word(in_word_t w);
        int unsigned n, r, c, vr;
        logic last;
        longint dx, dz;
        longint unsigned s;
        logic signed [15:0] nx, ny, nz;
        n = grid_n(grid_reg);
        if (w.command == CMD_DRAIN) begin
            if (next_row < n) return;
            last = (drain_pos + 1 >= n);
            expected_vertices = {expected_vertices, make_vertex(n - 1, drain_pos,
                stored_height(n - 1, drain_pos), 16'sd0, UNIT_Q14, 16'sd0, n, last)};
            if (last) begin
                next_row = 0;
                next_col = 0;
                drain_pos = 0;
                meshes_done++;
            end else begin
                drain_pos++;
            end
            return;
        end
        if (next_row >= n) return;
        r = next_row;
        c = next_col;
        if (r >= 1) begin
            vr = r - 1;
            nx = 16'sd0;
            ny = UNIT_Q14;
            nz = 16'sd0;
            if (vr >= 1 && c >= 1 && c + 2 <= n) begin
                dx = longint'(w.height) - longint'(stored_height(r, c));
                dz = longint'(stored_height(vr, c + 1)) - longint'(stored_height(vr, c - 1));
                s = dx * dx + dz * dz + (64'd1 << SLOPE_SQ_LOG2);
                nx = unit_component(-dx, s);
                ny = unit_component(8192, s);
                nz = unit_component(-dz, s);
            end
            expected_vertices = {expected_vertices, make_vertex(vr, c, stored_height(vr, c),
                nx, ny, nz, n, 1'b0)};
        end
        line_mem[(r & 1) * STORE_ROWS + (c % STORE_ROWS)] = w.height;
        if (c + 1 >= n) begin
            next_col = 0;
            next_row = r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_word(s_data);
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    s_data <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected vertex word row %0d col %0d", m_data.grid_row,
                    m_data.grid_col);
                errors++;
            end else begin
                want = expected_vertices.pop_front();
                check_field("grid_row", want.grid_row, m_data.grid_row);
                check_field("grid_col", want.grid_col, m_data.grid_col);
                check_field("elevation", want.elevation, m_data.elevation);
                check_field("normal_x", want.normal_x, m_data.normal_x);
                check_field("normal_y", want.normal_y, m_data.normal_y);
                check_field("normal_z", want.normal_z, m_data.normal_z);
                check_field("tex_u", want.tex_u, m_data.tex_u);
                check_field("tex_v", want.tex_v, m_data.tex_v);
                check_field("mesh_last", want.mesh_last, m_data.mesh_last);
                vertices_checked++;
            end
        end
    end

    task automatic write_reg(logic idx, int unsigned value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(int'(idx) * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GRID_SIZE) begin
            grid_reg = value & 9'h1FF;
            next_row = 0;
            next_col = 0;
            drain_pos = 0;
        end else begin
            scale_reg = value & 16'hFFFF;
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_vertices.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic push_word(logic cmd, logic signed [15:0] h);
        in_word_t w;
        w.command = cmd;
        w.height = h;
        pending_words = {pending_words, w};
        words_sent++;
    endtask

    function automatic logic signed [15:0] random_height(int style, logic signed [15:0] base);
        if (style == 0) return 16'($urandom);
        return base + 16'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    // A stop value below n*n leaves the mesh partial.
    task automatic push_mesh(int unsigned n, int unsigned stop_at);
        int style;
        logic signed [15:0] base;
        style = $urandom_range(0, 2);
        base = 16'($urandom);
        for (int unsigned k = 0; k < n * n && k < stop_at; k++) begin
            if ($urandom_range(99) < 3) push_word(CMD_DRAIN, 16'($urandom));
            base = random_height(style, base);
            push_word(CMD_SAMPLE, base);
        end
        if (stop_at < n * n) return;
        if ($urandom_range(99) < 20) push_word(CMD_SAMPLE, 16'($urandom));
        for (int unsigned k = 0; k < n; k++) push_word(CMD_DRAIN, 16'($urandom));
    endtask

    initial begin
        int unsigned sz, n, sc;
        int phase;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_GRID_SIZE, 0);
        write_reg(REG_HEIGHT_SCALE, 65535);
        push_word(CMD_DRAIN, 16'sd0);
        push_word(CMD_SAMPLE, -16'sd32768);
        push_word(CMD_SAMPLE, 16'sd32767);
        push_word(CMD_SAMPLE, -16'sd32768);
        push_word(CMD_SAMPLE, 16'sd32767);
        push_word(CMD_SAMPLE, -16'sd32768);
        push_word(CMD_SAMPLE, 16'sd32767);
        push_word(CMD_SAMPLE, -16'sd32768);
        push_word(CMD_DRAIN, 16'sd0);
        push_word(CMD_SAMPLE, 16'sd0);
        push_word(CMD_SAMPLE, 16'sd32767);
        push_word(CMD_SAMPLE, -16'sd1);
        push_word(CMD_SAMPLE, 16'sd5);
        for (int k = 0; k < 3; k++) push_word(CMD_DRAIN, -16'sd1);
        wait_idle();

        write_reg(REG_GRID_SIZE, 511);
        write_reg(REG_HEIGHT_SCALE, 0);
        push_mesh(256, 300);
        wait_idle();
        write_reg(REG_GRID_SIZE, 256);
        write_reg(REG_HEIGHT_SCALE, HEIGHT_SCALE_RST);
        push_mesh(256, 20);
        wait_idle();

        phase = 0;
        while (words_sent < 1050) begin
            gap_pct = (phase % 4 == 1) ? 57 : (phase % 4 == 3) ? 12 : 0;
            stall_pct = (phase % 4 == 2) ? 57 : (phase % 4 == 3) ? 12 : 0;
            case ($urandom_range(0, 9))
                0: sz = $urandom_range(0, 2);
                1: sz = $urandom_range(10, 16);
                default: sz = $urandom_range(3, 8);
            endcase
            case ($urandom_range(0, 3))
                0: sc = 0;
                1: sc = 65535;
                default: sc = $urandom_range(0, 65535);
            endcase
            write_reg(REG_GRID_SIZE, sz);
            write_reg(REG_HEIGHT_SCALE, sc);
            n = grid_n(sz);
            if (phase == 2) hold_requests++;
            for (int m = $urandom_range(1, 2); m > 0; m--)
                push_mesh(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, n * n) : n * n);
            wait_idle();
            phase++;
        end

        $display("Checked %0d vertex words from %0d input words; %0d meshes completed.",
            vertices_checked, words_sent, meshes_done);
        $display("Covered grid sizes from 3 to 256 and scales 0 to 65535 under idling phases.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
